@@ design/rlu_pkg.sv @@
// Shared types, register indexes and constants for the regression loss unit.
`timescale 1ns / 1ps
package rlu_pkg;

   localparam int unsigned FRAC_BITS_DEFAULT    = 16;
   localparam int unsigned MAX_ELEMENTS_DEFAULT = 1048576;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 31;
   localparam int unsigned THR_W       = 31;
   localparam int unsigned COUNT_W     = 21;
   localparam int unsigned MAG_W       = 32;
   localparam int unsigned RESULT_W    = 48;

   localparam logic [CSR_INDEX_W-1:0] REG_LOSS_KIND      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DIRECTION      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REDUCTION_MODE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LOSS_THRESHOLD = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ELEMENT_COUNT  = 3'd4;

   localparam logic [1:0] KIND_SQUARED   = 2'd0;
   localparam logic [1:0] KIND_ABSOLUTE  = 2'd1;
   localparam logic [1:0] KIND_SMOOTH_L1 = 2'd2;
   localparam logic [1:0] KIND_HUBER     = 2'd3;

   localparam logic DIR_LOSS = 1'b0;
   localparam logic DIR_GRAD = 1'b1;

   localparam logic [1:0] RED_NONE = 2'd0;
   localparam logic [1:0] RED_MEAN = 2'd1;
   localparam logic [1:0] RED_SUM  = 2'd2;

   localparam logic [63:0] ACC_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] POS_LIMIT = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT = 64'h0000_8000_0000_0000;

   // One classified element on its way from the front to the back.
   typedef struct packed {
      logic               neg;
      logic [MAG_W-1:0]   mag;
      logic               below;
      logic               last;
      logic [1:0]         kind;
      logic               dir;
      logic [1:0]         red;
      logic [THR_W-1:0]   thr;
      logic [COUNT_W-1:0] count;
      logic               bad;
   } item_type;

endpackage

@@ design/rlu_front.sv @@
// Front end: configuration registers, difference and classification of each word.
`timescale 1ns / 1ps
module rlu_front #(
   parameter int unsigned MAX_ELEMENTS = rlu_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [31:0]                   req_prediction,
   input  logic signed [31:0]                   req_target,
   input  logic                                 req_last_element,
   input  logic                                 csr_write_enable,
   input  logic [rlu_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rlu_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic                                 queue_full,
   output logic                                 push_valid,
   output rlu_pkg::item_type                    push_item
);
   import rlu_pkg::*;

   logic [1:0]         loss_kind_ff;
   logic               direction_ff;
   logic [1:0]         reduction_mode_ff;
   logic [THR_W-1:0]   loss_threshold_ff;
   logic [COUNT_W-1:0] element_count_ff;

   logic signed [32:0] diff;
   logic [32:0]        diff_neg;
   logic [MAG_W-1:0]   mag;
   logic [COUNT_W-1:0] div_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         loss_kind_ff      <= KIND_SQUARED;
         direction_ff      <= DIR_LOSS;
         reduction_mode_ff <= RED_MEAN;
         loss_threshold_ff <= 31'd65536;
         element_count_ff  <= 21'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_LOSS_KIND:      loss_kind_ff      <= csr_write_data[1:0];
            REG_DIRECTION:      direction_ff      <= csr_write_data[0];
            REG_REDUCTION_MODE: reduction_mode_ff <= csr_write_data[1:0];
            REG_LOSS_THRESHOLD: loss_threshold_ff <= csr_write_data[THR_W-1:0];
            REG_ELEMENT_COUNT:  element_count_ff  <= csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign diff     = {req_prediction[31], req_prediction} - {req_target[31], req_target};
   assign diff_neg = 33'd0 - diff;
   assign mag      = diff[32] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];

   // Clamp the mean divisor: zero divides by one, large counts by the ceiling.
   always_comb begin
      if (element_count_ff == '0)
         div_count = COUNT_W'(1);
      else if ({11'd0, element_count_ff} > 32'(MAX_ELEMENTS))
         div_count = COUNT_W'(MAX_ELEMENTS);
      else
         div_count = element_count_ff;
   end

   assign req_ready  = !queue_full;
   assign push_valid = req_valid && !queue_full;

   always_comb begin
      push_item.neg   = diff[32];
      push_item.mag   = mag;
      push_item.below = mag < {1'b0, loss_threshold_ff};
      push_item.last  = req_last_element;
      push_item.kind  = loss_kind_ff;
      push_item.dir   = direction_ff;
      push_item.red   = reduction_mode_ff;
      push_item.thr   = loss_threshold_ff;
      push_item.count = div_count;
      push_item.bad   = (loss_kind_ff == KIND_HUBER) && (loss_threshold_ff == '0);
   end

endmodule

@@ design/rlu_queue.sv @@
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module rlu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rlu_pkg::item_type push_item,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output rlu_pkg::item_type head
);
   import rlu_pkg::*;

   localparam logic [1:0] COUNT_EMPTY = 2'd0;
   localparam logic [1:0] COUNT_FULL  = 2'd2;

   item_type   mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full  = count_ff == COUNT_FULL;
   assign empty = count_ff == COUNT_EMPTY;
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= COUNT_EMPTY;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop)
            count_ff <= count_ff + 2'd1;
         else if (pop && !push)
            count_ff <= count_ff - 2'd1;
      end
   end

endmodule

@@ design/rlu_divider.sv @@
// Restoring divider, one quotient bit per cycle, quotient rounded half up.
`timescale 1ns / 1ps
module rlu_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  step_ff;
   logic [63:0] num_ff;
   logic [31:0] rem_ff;
   logic [31:0] den_ff;

   logic [32:0] rem_shift;
   logic [32:0] rem_sub;
   logic        fits;
   logic        round_up;

   assign rem_shift = {rem_ff, num_ff[63]};
   assign rem_sub   = rem_shift - {1'b0, den_ff};
   assign fits      = rem_shift >= {1'b0, den_ff};
   assign round_up  = {rem_ff, 1'b0} >= {1'b0, den_ff};

   assign done     = done_ff;
   assign quotient = num_ff + {63'd0, round_up};

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         num_ff <= {num_ff[62:0], fits};
         rem_ff <= fits ? rem_sub[31:0] : rem_shift[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

@@ design/rlu_back.sv @@
// Back end: sequencer with shared multiplier and divider, accumulator and result register.
`timescale 1ns / 1ps
module rlu_back #(
   parameter int unsigned FRAC_BITS = rlu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  queue_empty,
   input  rlu_pkg::item_type                     queue_head,
   output logic                                  queue_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [rlu_pkg::RESULT_W-1:0]   rsp_result_value,
   output logic                                  rsp_is_last,
   output logic                                  rsp_saturated,
   output logic                                  rsp_bad_threshold
);
   import rlu_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_ELEM = 3'd3;
   localparam logic [2:0] ST_DIV1 = 3'd4;
   localparam logic [2:0] ST_POST = 3'd5;
   localparam logic [2:0] ST_DIV2 = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

   logic [2:0]  state_ff;
   logic [2:0]  state_in;
   item_type    cur_ff;
   logic [63:0] prod1_ff;
   logic [61:0] prod2_ff;
   logic [63:0] val_ff;
   logic        sat_ff;
   logic [63:0] acc_ff;
   logic        ovf_ff;

   logic                rsp_valid_ff;
   logic [RESULT_W-1:0] rsp_value_ff;
   logic                rsp_last_ff;
   logic                rsp_sat_ff;
   logic                rsp_bad_ff;

   logic [31:0] mul_a;
   logic [64:0] sq_round;
   logic [64:0] hub_small;
   logic [65:0] hub_large;
   logic [33:0] smooth_large;
   logic [63:0] elem_val;
   logic        elem_div;
   logic [63:0] elem_num;
   logic [31:0] elem_den;

   logic [64:0] acc_sum;
   logic        acc_over;
   logic [63:0] acc_next;
   logic        reduce;

   logic        div_start;
   logic [63:0] div_num;
   logic [31:0] div_den;
   logic        div_done;
   logic [63:0] div_quo;

   logic                out_neg;
   logic                out_clip;
   logic [RESULT_W-1:0] out_value;
   logic [RESULT_W-1:0] neg_value;
   logic                out_free;

   rlu_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Huber above threshold needs T*m; otherwise the first product is m*m.
   assign mul_a = (cur_ff.kind == KIND_HUBER && !cur_ff.below) ? {1'b0, cur_ff.thr}
                                                               : cur_ff.mag;

   assign sq_round     = {1'b0, prod1_ff} + {1'b0, HALF};
   assign hub_small    = {1'b0, prod1_ff} + {1'b0, ONE};
   assign hub_large    = {1'b0, prod1_ff, 1'b0} - {4'd0, prod2_ff} + {2'd0, ONE};
   assign smooth_large = {1'b0, cur_ff.mag, 1'b0} - {3'd0, cur_ff.thr} + 34'd1;

   always_comb begin
      elem_val = '0;
      elem_div = 1'b0;
      elem_num = '0;
      elem_den = '0;
      if (cur_ff.dir == DIR_LOSS) begin
         case (cur_ff.kind)
            KIND_SQUARED:  elem_val = 64'(sq_round >> FRAC_BITS);
            KIND_ABSOLUTE: elem_val = {32'd0, cur_ff.mag};
            KIND_SMOOTH_L1: begin
               if (cur_ff.thr == '0) begin
                  elem_val = {32'd0, cur_ff.mag};
               end else if (cur_ff.below) begin
                  elem_div = 1'b1;
                  elem_num = prod1_ff;
                  elem_den = {cur_ff.thr, 1'b0};
               end else begin
                  elem_val = {31'd0, smooth_large[33:1]};
               end
            end
            default: begin
               if (cur_ff.bad)
                  elem_val = '0;
               else if (cur_ff.below)
                  elem_val = 64'(hub_small >> (FRAC_BITS + 1));
               else
                  elem_val = 64'(hub_large >> (FRAC_BITS + 1));
            end
         endcase
      end else begin
         case (cur_ff.kind)
            KIND_SQUARED:  elem_val = {31'd0, cur_ff.mag, 1'b0};
            KIND_ABSOLUTE: elem_val = (cur_ff.mag != '0) ? ONE : '0;
            KIND_SMOOTH_L1: begin
               if (cur_ff.below) begin
                  elem_div = 1'b1;
                  elem_num = {32'd0, cur_ff.mag} << FRAC_BITS;
                  elem_den = {1'b0, cur_ff.thr};
               end else begin
                  elem_val = (cur_ff.mag != '0) ? ONE : '0;
               end
            end
            default: begin
               if (cur_ff.bad)
                  elem_val = '0;
               else if (cur_ff.below)
                  elem_val = {32'd0, cur_ff.mag};
               else
                  elem_val = {33'd0, cur_ff.thr};
            end
         endcase
      end
   end

   // Saturating running sum of losses.
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, val_ff};
   assign acc_over = acc_sum > {1'b0, ACC_LIMIT};
   assign acc_next = acc_over ? ACC_LIMIT : acc_sum[63:0];
   assign reduce   = (cur_ff.dir == DIR_LOSS)
                     && (cur_ff.red == RED_MEAN || cur_ff.red == RED_SUM);

   always_comb begin
      div_start = 1'b0;
      div_num   = elem_num;
      div_den   = elem_den;
      if (state_ff == ST_ELEM) begin
         div_start = elem_div;
      end else if (state_ff == ST_POST) begin
         div_num = (cur_ff.dir == DIR_GRAD) ? val_ff : acc_next;
         div_den = {11'd0, cur_ff.count};
         div_start = (cur_ff.red == RED_MEAN) && (cur_ff.dir == DIR_GRAD || cur_ff.last);
      end
   end

   // Clip the magnitude to the signed 48-bit result range.
   assign out_neg   = (cur_ff.dir == DIR_GRAD) && cur_ff.neg;
   assign neg_value = '0 - val_ff[RESULT_W-1:0];
   always_comb begin
      out_clip  = 1'b0;
      out_value = '0;
      if (val_ff != '0) begin
         if (out_neg) begin
            out_clip  = val_ff > NEG_LIMIT;
            out_value = out_clip ? NEG_LIMIT[RESULT_W-1:0] : neg_value;
         end else begin
            out_clip  = val_ff > POS_LIMIT;
            out_value = out_clip ? POS_LIMIT[RESULT_W-1:0] : val_ff[RESULT_W-1:0];
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign queue_pop = (state_ff == ST_IDLE) && !queue_empty;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (!queue_empty) state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_ELEM;
         ST_ELEM: state_in = elem_div ? ST_DIV1 : ST_POST;
         ST_DIV1: if (div_done) state_in = ST_POST;
         ST_POST: begin
            if (div_start)
               state_in = ST_DIV2;
            else if (reduce && !cur_ff.last)
               state_in = ST_IDLE;
            else
               state_in = ST_OUT;
         end
         ST_DIV2: if (div_done) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (state_ff == ST_POST && reduce) begin
         if (cur_ff.last) begin
            acc_ff <= '0;
            ovf_ff <= 1'b0;
         end else begin
            acc_ff <= acc_next;
            ovf_ff <= ovf_ff || acc_over;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (!queue_empty) cur_ff <= queue_head;
         ST_MUL1: prod1_ff <= {32'd0, mul_a} * {32'd0, cur_ff.mag};
         ST_MUL2: prod2_ff <= {31'd0, cur_ff.thr} * {31'd0, cur_ff.thr};
         ST_ELEM: begin
            val_ff <= elem_val;
            sat_ff <= 1'b0;
         end
         ST_DIV1: if (div_done) val_ff <= div_quo;
         ST_POST: begin
            if (reduce && cur_ff.last) begin
               val_ff <= acc_next;
               sat_ff <= ovf_ff || acc_over;
            end
         end
         ST_DIV2: if (div_done) val_ff <= div_quo;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_value_ff <= out_value;
         rsp_last_ff  <= cur_ff.last;
         rsp_sat_ff   <= sat_ff || out_clip;
         rsp_bad_ff   <= cur_ff.bad;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_value  = rsp_value_ff;
   assign rsp_is_last       = rsp_last_ff;
   assign rsp_saturated     = rsp_sat_ff;
   assign rsp_bad_threshold = rsp_bad_ff;

endmodule

@@ design/regression_loss_unit_core.sv @@
// Top level of the regression loss unit: front end, queue and back end.
`timescale 1ns / 1ps
// Computes squared, absolute, smooth L1 or Huber loss, or its gradient, for a stream
// of Q16.16 prediction/target words, either per element or reduced to a sum or mean
// at the word marked last. The front end takes a word in any cycle while the two-entry
// queue has room; the back end works on one word at a time, with a pass through the
// shared bit-serial divider for smooth L1 below threshold and for mean reduction of a
// gradient or of the final sum. Results wait in an output register and saturate to
// signed 48 bits.
module regression_loss_unit_core #(
   parameter int unsigned FRAC_BITS    = rlu_pkg::FRAC_BITS_DEFAULT,
   parameter int unsigned MAX_ELEMENTS = rlu_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [31:0]                  req_prediction,
   input  logic signed [31:0]                  req_target,
   input  logic                                req_last_element,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rlu_pkg::RESULT_W-1:0] rsp_result_value,
   output logic                                rsp_is_last,
   output logic                                rsp_saturated,
   output logic                                rsp_bad_threshold,
   input  logic                                csr_write_enable,
   input  logic [rlu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rlu_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import rlu_pkg::*;

   logic     push_valid;
   item_type push_item;
   logic     queue_full;
   logic     queue_empty;
   logic     queue_pop;
   item_type queue_head;

   rlu_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_prediction   (req_prediction),
      .req_target       (req_target),
      .req_last_element (req_last_element),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_item        (push_item)
   );

   rlu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .pop       (queue_pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (queue_head)
   );

   rlu_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .queue_head        (queue_head),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_value  (rsp_result_value),
      .rsp_is_last       (rsp_is_last),
      .rsp_saturated     (rsp_saturated),
      .rsp_bad_threshold (rsp_bad_threshold)
   );

endmodule

@@ sim/tb_regression_loss_unit_core.sv @@
// Self-checking testbench for regression_loss_unit_core: random config phases, scoreboard.
`timescale 1ns / 1ps
module tb_regression_loss_unit_core;
   import rlu_pkg::*;

   localparam int unsigned FRAC     = 16;
   localparam logic [63:0] MAX_ELEM = 64'd1048576;
   localparam int unsigned SETTLE   = 400;

   typedef struct {
      logic [31:0] prediction;
      logic [31:0] target;
      logic        last;
   } element_type;

   typedef struct {
      logic [RESULT_W-1:0] value;
      logic                last;
      logic                saturated;
      logic                bad_threshold;
   } loss_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_prediction = '0;
   logic signed [31:0] req_target = '0;
   logic req_last_element = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [RESULT_W-1:0] rsp_result_value;
   logic rsp_is_last, rsp_saturated, rsp_bad_threshold;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   regression_loss_unit_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_prediction(req_prediction), .req_target(req_target),
      .req_last_element(req_last_element),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_is_last(rsp_is_last),
      .rsp_saturated(rsp_saturated), .rsp_bad_threshold(rsp_bad_threshold),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state and configuration shadow
   logic [1:0]  cfg_kind = KIND_SQUARED;
   logic        cfg_dir = DIR_LOSS;
   logic [1:0]  cfg_red = RED_MEAN;
   logic [30:0] cfg_thr = 31'd65536;
   logic [20:0] cfg_count = 21'd1;
   logic [63:0] loss_sum = '0;
   logic        sum_clipped = 1'b0;

   element_type     words_pending[$];
   loss_result_type loss_results_due[$];
   int unsigned  words_offered = 0;
   int unsigned  words_taken = 0;
   int unsigned  results_checked = 0;
   int unsigned  mismatches = 0;
   int unsigned  phases = 0;
   bit           sender_quiet = 1'b0;
   bit           receiver_quiet = 1'b0;
   bit           hold_armed = 1'b0;
   bit           hold_done = 1'b0;

   function automatic logic [63:0] div_nearest(input logic [63:0] n, input logic [63:0] q);
      logic [63:0] r;
      r = n % q;
      return n / q + (((r * 2) >= q) ? 64'd1 : 64'd0);
   endfunction

   function automatic logic [63:0] mean_divisor();
      if (cfg_count == 0) return 64'd1;
      if (64'(cfg_count) > MAX_ELEM) return MAX_ELEM;
      return 64'(cfg_count);
   endfunction

   function automatic logic [RESULT_W-1:0] clip_signed(input logic neg, input logic [63:0] mag,
                                                       inout logic sat);
      logic [63:0] v;
      if (mag == 0) return '0;
      if (neg) begin
         if (mag > NEG_LIMIT) begin
            mag = NEG_LIMIT;
            sat = 1'b1;
         end
         v = 64'd0 - mag;
         return v[RESULT_W-1:0];
      end
      if (mag > POS_LIMIT) begin
         mag = POS_LIMIT;
         sat = 1'b1;
      end
      return mag[RESULT_W-1:0];
   endfunction

   // Work out the result of one accepted word, updating the running sum.
   function automatic void predict_loss_word(input element_type w);
      logic signed [63:0] d;
      logic neg, bad, sat;
      logic [63:0] m, thr, one, g, l;
      loss_result_type r;
      d = 64'($signed(w.prediction)) - 64'($signed(w.target));
      neg = d[63];
      m = neg ? 64'(-d) : 64'(d);
      thr = 64'(cfg_thr);
      one = 64'd1 << FRAC;
      bad = (cfg_kind == KIND_HUBER) && (thr == 0);
      sat = 1'b0;
      if (cfg_dir == DIR_GRAD) begin
         case (cfg_kind)
            KIND_SQUARED:  g = 2 * m;
            KIND_ABSOLUTE: g = (m != 0) ? one : 64'd0;
            KIND_SMOOTH_L1: begin
               if (thr == 0 || m >= thr) g = (m != 0) ? one : 64'd0;
               else g = div_nearest(m << FRAC, thr);
            end
            default: g = bad ? 64'd0 : ((m < thr) ? m : thr);
         endcase
         if (cfg_red == RED_MEAN) g = div_nearest(g, mean_divisor());
         r.value = clip_signed(neg, g, sat);
      end else begin
         case (cfg_kind)
            KIND_SQUARED:  l = (m * m + (one >> 1)) >> FRAC;
            KIND_ABSOLUTE: l = m;
            KIND_SMOOTH_L1: begin
               if (thr == 0) l = m;
               else if (m < thr) l = div_nearest(m * m, 2 * thr);
               else l = (2 * m - thr + 1) >> 1;
            end
            default: begin
               if (bad) l = 0;
               else if (m < thr) l = (m * m + one) >> (FRAC + 1);
               else l = (2 * thr * m - thr * thr + one) >> (FRAC + 1);
            end
         endcase
         if (cfg_red == RED_MEAN || cfg_red == RED_SUM) begin
            if (l > ACC_LIMIT - loss_sum) begin
               loss_sum = ACC_LIMIT;
               sum_clipped = 1'b1;
            end else begin
               loss_sum = loss_sum + l;
            end
            if (!w.last) return;
            l = loss_sum;
            if (cfg_red == RED_MEAN) l = div_nearest(l, mean_divisor());
            sat = sum_clipped;
            loss_sum = '0;
            sum_clipped = 1'b0;
         end
         r.value = clip_signed(1'b0, l, sat);
      end
      r.last = w.last;
      r.saturated = sat;
      r.bad_threshold = bad;
      loss_results_due.push_back(r);
   endfunction

   // sender: one word per handshake, random gap after each word
   element_type word_held;
   element_type word_next;
   int unsigned send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_loss_word(word_held);
            words_taken++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (words_pending.size() != 0) begin
               word_next = words_pending.pop_front();
               word_held <= word_next;
               req_prediction <= word_next.prediction;
               req_target <= word_next.target;
               req_last_element <= word_next.last;
               req_valid <= 1'b1;
               send_gap <= sender_quiet ? 0 : $urandom_range(0, 16);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each result against the oldest expectation, stall at random
   int unsigned  recv_stall = 0;
   int unsigned  hold_left = 0;
   int unsigned  stall_now;
   loss_result_type due;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_now = (recv_stall != 0) ? recv_stall - 1 : 0;
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            stall_now = receiver_quiet ? 0 : $urandom_range(0, 16);
            if (loss_results_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result value=%h last=%b sat=%b bad=%b", $time,
                        rsp_result_value, rsp_is_last, rsp_saturated, rsp_bad_threshold);
            end else begin
               due = loss_results_due.pop_front();
               if (rsp_result_value !== due.value) begin
                  mismatches++;
                  $display("%0t: result_value expected %h actual %h", $time, due.value,
                           rsp_result_value);
               end
               if (rsp_is_last !== due.last) begin
                  mismatches++;
                  $display("%0t: is_last expected %b actual %b", $time, due.last, rsp_is_last);
               end
               if (rsp_saturated !== due.saturated) begin
                  mismatches++;
                  $display("%0t: saturated expected %b actual %b", $time, due.saturated,
                           rsp_saturated);
               end
               if (rsp_bad_threshold !== due.bad_threshold) begin
                  mismatches++;
                  $display("%0t: bad_threshold expected %b actual %b", $time,
                           due.bad_threshold, rsp_bad_threshold);
               end
            end
         end
         // long hold-off: let the block fill and push back on the sender
         if (hold_armed && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 600;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (stall_now == 0);
         end
         recv_stall <= stall_now;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [30:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input logic [1:0] kind, input logic dir, input logic [1:0] red,
                            input logic [30:0] thr, input logic [20:0] count);
      write_reg(REG_LOSS_KIND, 31'(kind));
      write_reg(REG_DIRECTION, 31'(dir));
      write_reg(REG_REDUCTION_MODE, 31'(red));
      write_reg(REG_LOSS_THRESHOLD, thr);
      write_reg(REG_ELEMENT_COUNT, 31'(count));
      cfg_kind = kind;
      cfg_dir = dir;
      cfg_red = red;
      cfg_thr = thr;
      cfg_count = count;
      phases++;
   endtask

   task automatic offer(input logic [31:0] p, input logic [31:0] t, input logic last);
      element_type w;
      w.prediction = p;
      w.target = t;
      w.last = last;
      words_pending.push_back(w);
      words_offered++;
   endtask

   // wait until the block has drained, then for its worst-case latency
   task automatic drain();
      while (words_pending.size() != 0 || req_valid || loss_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic offer_random(input logic last);
      logic [31:0] p, t;
      p = pick_word();
      case ($urandom_range(0, 5))
         0: t = p;
         1, 2: t = p + 32'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
         default: t = pick_word();
      endcase
      offer(p, t, last);
   endtask

   function automatic logic [30:0] pick_threshold();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return 31'h7FFF_FFFF;
         2: return 31'd65536;
         3, 4: return 31'($urandom_range(1, 32'h4_0000));
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic logic [20:0] pick_count();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return 21'd1;
         2: return 21'd1048576;
         3: return 21'h1F_FFFF;
         4: return 21'($urandom);
         default: return 21'($urandom_range(2, 64));
      endcase
   endfunction

   int unsigned n, k, len;
   logic [1:0] red;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings first, then each kind, direction and corner
      offer(32'h0, 32'h0, 1'b1);
      offer(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      offer(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      drain();
      configure(KIND_SQUARED, DIR_LOSS, RED_NONE, 31'd65536, 21'd1);
      offer(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      offer(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      offer(32'h1, 32'h0, 1'b0);
      drain();
      configure(KIND_ABSOLUTE, DIR_GRAD, RED_MEAN, 31'd65536, 21'd0);
      offer(32'd5, 32'd9, 1'b0);
      offer(32'd9, 32'd5, 1'b1);
      offer(32'd3, 32'd3, 1'b0);
      drain();
      configure(KIND_SMOOTH_L1, DIR_LOSS, RED_SUM, 31'd0, 21'd1);
      offer(32'd100, 32'd0, 1'b0);
      offer(32'd0, 32'd100, 1'b1);
      drain();
      configure(KIND_SMOOTH_L1, DIR_GRAD, RED_NONE, 31'h1_0000, 21'd1);
      offer(32'h8000, 32'h0, 1'b0);
      offer(32'h0, 32'h2_0000, 1'b1);
      drain();
      configure(KIND_HUBER, DIR_LOSS, RED_NONE, 31'd0, 21'd1);
      offer(32'd7, 32'd1, 1'b1);
      drain();
      // reduction selector 3 acts as elementwise; count above the cap
      configure(KIND_HUBER, DIR_GRAD, 2'd3, 31'h7FFF_FFFF, 21'h1F_FFFF);
      offer(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      offer(32'd1, 32'd2, 1'b0);
      drain();
      configure(KIND_HUBER, DIR_LOSS, RED_MEAN, 31'h3_0000, 21'd3);
      offer(32'h1_0000, 32'h0, 1'b0);
      offer(32'h5_0000, 32'h0, 1'b0);
      offer(32'h0, 32'h0, 1'b1);
      drain();
      configure(KIND_SQUARED, DIR_GRAD, RED_MEAN, 31'd65536, 21'd1048576);
      offer(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      drain();

      // random phases; the second is elementwise, and the first elementwise one gets a long receiver hold-off
      while (words_offered < 1950) begin
         red = (phases == 9) ? RED_NONE : 2'($urandom_range(0, 3));
         configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), red,
                   pick_threshold(), pick_count());
         sender_quiet = ($urandom_range(0, 3) == 0);
         receiver_quiet = ($urandom_range(0, 3) == 0);
         n = $urandom_range(20, 70);
         k = 0;
         while (k < n) begin
            len = $urandom_range(1, 8);
            repeat (len) begin
               k++;
               if (cfg_dir == DIR_LOSS && (cfg_red == RED_MEAN || cfg_red == RED_SUM))
                  offer_random(k == n || len == 1);
               else
                  offer_random(1'($urandom_range(0, 1)) || k == n);
               len--;
            end
         end
         if (red == RED_NONE && !hold_armed) begin
            sender_quiet = 1'b1;
            hold_armed = 1'b1;
         end
         drain();
      end

      $display("Ran %0d config phases: %0d words taken, %0d results checked.", phases,
               words_taken, results_checked);
      $display("Covered all loss kinds, both directions and every reduction mode.");
      if (mismatches == 0 && loss_results_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d results outstanding.", loss_results_due.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ regression_loss_unit_core.f @@
design/rlu_pkg.sv
design/rlu_front.sv
design/rlu_queue.sv
design/rlu_divider.sv
design/rlu_back.sv
design/regression_loss_unit_core.sv
sim/tb_regression_loss_unit_core.sv
